/* sv/iprhp_pkg.sv */
// Package: shared types and status codes for the IPv4 receive header parser.
package iprhp_pkg;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0]  MIN_FRAME_BYTES = 8'd20;
    localparam logic [5:0]  MIN_HDR_BYTES   = 6'd20;
    localparam logic [3:0]  IP_VERSION      = 4'd4;
    localparam logic [7:0]  PROTO_ICMP      = 8'd1;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [15:0] IDX_VER_IHL     = 16'd0;
    localparam logic [15:0] IDX_TOTLEN_HI   = 16'd2;
    localparam logic [15:0] IDX_TOTLEN_LO   = 16'd3;
    localparam logic [15:0] IDX_PROTO       = 16'd9;
    localparam logic [15:0] IDX_MAX         = 16'hFFFF;

    localparam logic ROUTE_ICMP = 1'b0;
    localparam logic ROUTE_UDP  = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SMALL   = 3'd1;
    localparam logic [2:0] ST_VERSION = 3'd2;
    localparam logic [2:0] ST_HDRLEN  = 3'd3;
    localparam logic [2:0] ST_TOTLEN  = 3'd4;
    localparam logic [2:0] ST_PROTO   = 3'd5;
    localparam logic [2:0] ST_TRUNC   = 3'd6;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       payload_last;
        logic       route;
        logic       status_valid;
        logic [2:0] status;
    } t_result;

endpackage

/* sv/iprhp_if.sv */
// Interfaces: byte input channel and result output channel.
interface iprhp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
    logic        end_of_frame;

    modport source (output valid, output data_byte, output frame_length,
                    output end_of_frame, input ready);
    modport sink   (input valid, input data_byte, input frame_length,
                    input end_of_frame, output ready);
endinterface

interface iprhp_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       payload_last;
    logic       route;
    logic       status_valid;
    logic [2:0] status;

    modport source (output valid, output payload_valid, output payload_byte,
                    output payload_last, output route, output status_valid,
                    output status, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input payload_last, input route, input status_valid,
                    input status, output ready);
endinterface

/* sv/ipv4_receive_header_parser.sv */
// Top level: IPv4 receive header parser, one frame byte per transaction.
//
// Input channel i_in: one frame byte per transaction with the frame's byte
// length and an end-of-frame flag. Output channel o_out: exactly one result
// transaction per input transaction, in order. A result carries a payload byte
// (with last flag and ICMP/UDP route) when the byte lies between the header
// end and the IPv4 total length of a frame that has passed all checks so far,
// and a status code on the frame's final byte.
// A result is written into the queue at the edge that accepts its byte and
// moves into the output register once that register is empty or being taken.
// Throughput: one byte per cycle sustained while the receiver holds o_out.ready
// high; the front end holds only counters and header fields, and the two-entry
// queue plus output register keep input acceptance going while a result waits.
// Reset (synchronous, active low) clears the frame state, empties the queue
// and drops the output valid. When the receiver stalls, the queue fills and
// i_in.ready falls after two more bytes; nothing is lost.
module ipv4_receive_header_parser import iprhp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    iprhp_in_if.sink     i_in,
    iprhp_out_if.source  o_out
);

    logic    accept;
    logic    full;
    logic    empty;
    logic    pop;
    t_result front_res;
    t_result queue_res;

    assign i_in.ready = !full;
    assign accept     = i_in.valid && !full;

    iprhp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_in.data_byte),
        .i_frame_length (i_in.frame_length),
        .i_end_of_frame (i_in.end_of_frame),
        .o_result       (front_res)
    );

    iprhp_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_push_data (front_res),
        .o_full      (full),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_pop_data  (queue_res)
    );

    iprhp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_data  (queue_res),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

/* sv/iprhp_front.sv */
// Front end: header field tracking, frame checks and per-byte result build.
module iprhp_front import iprhp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_frame_length,
    input  logic        i_end_of_frame,
    output t_result     o_result
);

    logic [15:0] r_byte_index, n_byte_index;
    logic [5:0]  r_header_bytes, n_header_bytes;
    logic [15:0] r_total_bytes, n_total_bytes;
    logic        r_route_class, n_route_class;
    logic [2:0]  r_frame_status, n_frame_status;

    logic [5:0]  hdr_new;
    logic [15:0] tot_new;
    logic [16:0] idx_inc;
    t_result     res;

    always_comb begin
        hdr_new        = {i_data_byte[3:0], 2'b00};
        tot_new        = {r_total_bytes[15:8], i_data_byte};
        idx_inc        = {1'b0, r_byte_index} + 17'd1;
        n_byte_index   = r_byte_index;
        n_header_bytes = r_header_bytes;
        n_total_bytes  = r_total_bytes;
        n_route_class  = r_route_class;
        n_frame_status = r_frame_status;
        res            = '0;
        if (i_accept) begin
            if (r_frame_status == ST_OK) begin
                if (r_byte_index == IDX_VER_IHL) begin
                    if (i_frame_length < {8'd0, MIN_FRAME_BYTES}) begin
                        n_frame_status = ST_SMALL;
                    end else if (i_data_byte[7:4] != IP_VERSION) begin
                        n_frame_status = ST_VERSION;
                    end else begin
                        n_header_bytes = hdr_new;
                        if (hdr_new < MIN_HDR_BYTES || {10'd0, hdr_new} > i_frame_length) begin
                            n_frame_status = ST_HDRLEN;
                        end
                    end
                end else if (r_byte_index == IDX_TOTLEN_HI) begin
                    n_total_bytes = {i_data_byte, 8'h00};
                end else if (r_byte_index == IDX_TOTLEN_LO) begin
                    n_total_bytes = tot_new;
                    if (tot_new < {10'd0, r_header_bytes} || tot_new > i_frame_length) begin
                        n_frame_status = ST_TOTLEN;
                    end
                end else if (r_byte_index == IDX_PROTO) begin
                    if (i_data_byte == PROTO_ICMP) begin
                        n_route_class = ROUTE_ICMP;
                    end else if (i_data_byte == PROTO_UDP) begin
                        n_route_class = ROUTE_UDP;
                    end else begin
                        n_frame_status = ST_PROTO;
                    end
                end else if (r_byte_index >= {10'd0, r_header_bytes}
                             && r_byte_index < r_total_bytes
                             && r_header_bytes >= MIN_HDR_BYTES) begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = i_data_byte;
                    res.payload_last  = (idx_inc == {1'b0, r_total_bytes});
                    res.route         = r_route_class;
                end
            end
            if (i_end_of_frame) begin
                res.status_valid = 1'b1;
                if (n_frame_status != ST_OK) begin
                    res.status = n_frame_status;
                end else if (idx_inc != {1'b0, i_frame_length}) begin
                    res.status = ST_TRUNC;
                end else begin
                    res.status = ST_OK;
                end
                n_byte_index   = '0;
                n_header_bytes = '0;
                n_total_bytes  = '0;
                n_route_class  = ROUTE_ICMP;
                n_frame_status = ST_OK;
            end else if (r_byte_index != IDX_MAX) begin
                n_byte_index = idx_inc[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index   <= '0;
            r_header_bytes <= '0;
            r_total_bytes  <= '0;
            r_route_class  <= ROUTE_ICMP;
            r_frame_status <= ST_OK;
        end else begin
            r_byte_index   <= n_byte_index;
            r_header_bytes <= n_header_bytes;
            r_total_bytes  <= n_total_bytes;
            r_route_class  <= n_route_class;
            r_frame_status <= n_frame_status;
        end
    end

    assign o_result = res;

endmodule

/* sv/iprhp_fifo.sv */
// Short result queue between the front end and the output stage.
module iprhp_fifo import iprhp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_pop_data
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wptr, n_wptr;
    logic [FIFO_PTR_W-1:0]  r_rptr, n_rptr;
    logic [FIFO_CNT_W-1:0]  r_count, n_count;

    assign o_full     = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

/* sv/iprhp_back.sv */
// Output stage: pulls results from the queue into the output register.
module iprhp_back import iprhp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_result i_data,
    output logic    o_pop,
    iprhp_out_if.source o_out
);

    logic    r_valid;
    t_result r_data;

    assign o_pop = !i_empty && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.payload_valid = r_data.payload_valid;
    assign o_out.payload_byte  = r_data.payload_byte;
    assign o_out.payload_last  = r_data.payload_last;
    assign o_out.route         = r_data.route;
    assign o_out.status_valid  = r_data.status_valid;
    assign o_out.status        = r_data.status;

endmodule
